>>> src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

>>> src/slr_pkg.sv
package slr_pkg;

	localparam int SAMPLE_W         = 16;
	localparam int STEP_RATIO_W     = 24;
	localparam int RATIO_FRAC       = 16;
	localparam int PHASE_W          = 26;
	localparam int FRAC_BITS_DEF    = 16;
	localparam int MAX_UPSAMPLE_DEF = 64;
	localparam int QUEUE_DEPTH_DEF  = 2;

	localparam logic [STEP_RATIO_W-1:0] STEP_RESET = 24'd65536;

	typedef enum logic {
		OP_PUSH  = 1'b0,
		OP_FLUSH = 1'b1
	} op_t;

	typedef struct packed {
		op_t                        op;
		logic signed [SAMPLE_W-1:0] sample;
	} cmd_t;

	typedef enum logic {
		ENG_IDLE,
		ENG_RUN
	} eng_state_t;

endpackage

>>> src/slr_front.sv
module slr_front import slr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [SAMPLE_W-1:0] s_axis_tdata,  // [15:0] sample
	input  logic [0:0]          s_axis_tuser,  // [0] operation
	output logic                q_valid,
	input  logic                q_ready,
	output cmd_t                q_cmd
);

	logic valid_s1;
	cmd_t cmd_s1;
	op_t  op_in;

	assign op_in         = op_t'(s_axis_tuser[0]);
	assign s_axis_tready = !valid_s1 || q_ready;
	assign q_valid       = valid_s1;
	assign q_cmd         = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// The sample of a flush word carries no meaning, so it is dropped here.
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cmd_s1.op     <= op_in;
			cmd_s1.sample <= (op_in == OP_FLUSH) ? '0 : $signed(s_axis_tdata);
		end
	end

endmodule

>>> src/slr_fifo.sv
module slr_fifo import slr_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  cmd_t in_cmd,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t out_cmd
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign in_ready  = (count_q != CNT_W'(DEPTH));
	assign out_valid = (count_q != '0);
	assign out_cmd   = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_cmd;
		end
	end

endmodule

>>> src/slr_back.sv
`include "assert_macros.svh"

module slr_back import slr_pkg::*; #(
	parameter int FRAC_BITS    = FRAC_BITS_DEF,
	parameter int MAX_UPSAMPLE = MAX_UPSAMPLE_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cmd_valid,
	output logic                    cmd_ready,
	input  cmd_t                    cmd,
	input  logic [STEP_RATIO_W-1:0] step_ratio,
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	output logic [SAMPLE_W-1:0]     m_axis_tdata,  // [15:0] value
	output logic [0:0]              m_axis_tuser,  // [0] end_of_stream
	output logic                    m_axis_tlast
);

	localparam int STEP_W = (FRAC_BITS >= RATIO_FRAC) ?
	                        STEP_RATIO_W + FRAC_BITS - RATIO_FRAC : STEP_RATIO_W;
	localparam int WPW    = ((PHASE_W > STEP_W) ? PHASE_W : STEP_W) + 1;
	localparam int INT_W  = WPW - FRAC_BITS;
	localparam int CNT_W  = $clog2(MAX_UPSAMPLE + 1);
	localparam int PROD_W = FRAC_BITS + SAMPLE_W + 2;
	localparam int MIN_STEP = ((1 << FRAC_BITS) + MAX_UPSAMPLE - 1) / MAX_UPSAMPLE;
	localparam logic [WPW-1:0]    ONE_POS = WPW'(1) << FRAC_BITS;
	localparam logic [PROD_W-1:0] HALF    = PROD_W'(1) << (FRAC_BITS - 1);

	// Stream state kept between words.
	eng_state_t                 state_q, state_d;
	logic signed [SAMPLE_W-1:0] older_q, newer_q;
	logic [1:0]                 held_q;
	logic [PHASE_W-1:0]         phase_q;

	// Working window of the word being processed.
	logic signed [SAMPLE_W-1:0] win_q [3];
	logic [1:0]                 size_q;
	logic [WPW-1:0]             ph_q;
	logic [WPW-1:0]             lim_q;
	logic [CNT_W-1:0]           n_q;

	// Interpolation pipeline.
	logic                       v_s1, eos_s1, last_s1;
	logic signed [SAMPLE_W-1:0] a_s1;
	logic signed [SAMPLE_W:0]   diff_s1;
	logic [FRAC_BITS-1:0]       frac_s1;
	logic                       v_s2, eos_s2, last_s2;
	logic signed [SAMPLE_W-1:0] a_s2;
	logic signed [PROD_W-1:0]   prod_s2;
	logic                       out_valid_q, eos_q, last_q;
	logic [SAMPLE_W-1:0]        value_q;

	logic [STEP_W-1:0] step_scaled;
	logic [WPW-1:0]    step_int;
	logic              adv;
	logic              run_cond, next_cond;
	logic [WPW-1:0]    ph_next;
	logic              sel_j;
	logic signed [SAMPLE_W-1:0] a_sel, b_sel, flush_val;

	logic                       load_push, do_flush, do_issue, do_finish;
	logic                       iss_valid, iss_eos, iss_last;
	logic signed [SAMPLE_W-1:0] iss_a;
	logic signed [SAMPLE_W:0]   iss_diff;
	logic [FRAC_BITS-1:0]       iss_frac;

	logic [INT_W-1:0]           drop;
	logic [1:0]                 maxd, d_raw, d_fin, rem_raw, rem_fin;
	logic [WPW-1:0]             ph_left;
	logic signed [SAMPLE_W-1:0] older_fin, newer_fin;

	logic signed [PROD_W-1:0]   rnd_sum;
	logic signed [PROD_W-1:0]   rnd_q;

	generate
		if (FRAC_BITS >= RATIO_FRAC) begin : g_scale_up
			assign step_scaled = STEP_W'(step_ratio) << (FRAC_BITS - RATIO_FRAC);
		end else begin : g_scale_down
			assign step_scaled = STEP_W'(step_ratio >> (RATIO_FRAC - FRAC_BITS));
		end
	endgenerate

	assign step_int = (step_scaled < STEP_W'(MIN_STEP)) ? WPW'(MIN_STEP) : WPW'(step_scaled);

	// The whole pipeline moves only while the output register can take a word.
	assign adv = !out_valid_q || m_axis_tready;

	assign run_cond  = (n_q < CNT_W'(MAX_UPSAMPLE)) && (size_q >= 2'd2) && (ph_q <= lim_q);
	assign ph_next   = ph_q + step_int;
	assign next_cond = (CNT_W'(n_q + 1'b1) < CNT_W'(MAX_UPSAMPLE)) && (ph_next <= lim_q);

	assign sel_j = ph_q[FRAC_BITS];
	assign a_sel = sel_j ? win_q[1] : win_q[0];
	assign b_sel = sel_j ? win_q[2] : win_q[1];

	assign flush_val = ((held_q == 2'd2) && (phase_q[PHASE_W-1:FRAC_BITS] != '0)) ?
	                   newer_q : older_q;

	// Drop the samples the phase has moved past, keeping the newest one and at most two.
	always_comb begin
		drop    = ph_q[WPW-1:FRAC_BITS];
		maxd    = size_q - 2'd1;
		d_raw   = (drop < INT_W'(maxd)) ? drop[1:0] : maxd;
		rem_raw = size_q - d_raw;
		if (rem_raw > 2'd2) begin
			d_fin   = size_q - 2'd2;
			rem_fin = 2'd2;
		end else begin
			d_fin   = d_raw;
			rem_fin = rem_raw;
		end
		ph_left = ph_q - (WPW'(d_fin) << FRAC_BITS);
		case (d_fin)
			2'd0:    older_fin = win_q[0];
			2'd1:    older_fin = win_q[1];
			default: older_fin = win_q[2];
		endcase
		if (rem_fin == 2'd2) begin
			newer_fin = (d_fin == 2'd0) ? win_q[1] : win_q[2];
		end else begin
			newer_fin = '0;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		load_push = 1'b0;
		do_flush  = 1'b0;
		do_issue  = 1'b0;
		do_finish = 1'b0;
		iss_valid = 1'b0;
		iss_a     = a_sel;
		iss_diff  = $signed({b_sel[SAMPLE_W-1], b_sel}) - $signed({a_sel[SAMPLE_W-1], a_sel});
		iss_frac  = ph_q[FRAC_BITS-1:0];
		iss_eos   = 1'b0;
		iss_last  = !next_cond;
		case (state_q)
			ENG_IDLE: begin
				cmd_ready = adv;
				if (cmd_valid && adv) begin
					if (cmd.op == OP_FLUSH) begin
						do_flush  = 1'b1;
						iss_valid = (held_q != 2'd0);
						iss_a     = flush_val;
						iss_diff  = '0;
						iss_frac  = '0;
						iss_eos   = 1'b1;
						iss_last  = 1'b1;
					end else begin
						load_push = 1'b1;
						state_d   = ENG_RUN;
					end
				end
			end
			ENG_RUN: begin
				if (run_cond) begin
					do_issue  = adv;
					iss_valid = adv;
				end else begin
					do_finish = 1'b1;
					state_d   = ENG_IDLE;
				end
			end
			default: begin
				state_d = ENG_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ENG_IDLE;
			older_q <= '0;
			newer_q <= '0;
			held_q  <= '0;
			phase_q <= '0;
			n_q     <= '0;
			size_q  <= '0;
		end else begin
			state_q <= state_d;
			if (do_flush) begin
				older_q <= '0;
				newer_q <= '0;
				held_q  <= '0;
				phase_q <= '0;
			end
			if (load_push) begin
				n_q    <= '0;
				size_q <= held_q + 2'd1;
			end
			if (do_issue) begin
				n_q <= n_q + 1'b1;
			end
			if (do_finish) begin
				older_q <= older_fin;
				newer_q <= newer_fin;
				held_q  <= rem_fin;
				phase_q <= ph_left[PHASE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_push) begin
			win_q[0] <= (held_q == 2'd0) ? cmd.sample : older_q;
			win_q[1] <= (held_q == 2'd1) ? cmd.sample : newer_q;
			win_q[2] <= (held_q == 2'd2) ? cmd.sample : '0;
			ph_q     <= WPW'(phase_q);
			lim_q    <= (held_q == 2'd2) ? ONE_POS : '0;
		end
		if (do_issue) begin
			ph_q <= ph_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= iss_valid;
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
		end
	end

	assign rnd_sum = prod_s2 + $signed(HALF);
	assign rnd_q   = rnd_sum >>> FRAC_BITS;

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1    <= iss_a;
			diff_s1 <= iss_diff;
			frac_s1 <= iss_frac;
			eos_s1  <= iss_eos;
			last_s1 <= iss_last;
			a_s2    <= a_s1;
			prod_s2 <= diff_s1 * $signed({1'b0, frac_s1});
			eos_s2  <= eos_s1;
			last_s2 <= last_s1;
			value_q <= a_s2 + $signed(rnd_q[SAMPLE_W-1:0]);
			eos_q   <= eos_s2;
			last_q  <= last_s2;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = value_q;
	assign m_axis_tuser[0] = eos_q;
	assign m_axis_tlast    = last_q;

	`ASSERT_ALWAYS(a_count_cap, clk, arst_n, n_q <= CNT_W'(MAX_UPSAMPLE), "emit count past cap")
	`ASSERT_ALWAYS(a_held_range, clk, arst_n, held_q <= 2'd2, "more than two samples held")
	`ASSERT_IMPL(a_window_index, clk, arst_n, state_q == ENG_RUN && run_cond, ph_q <= ONE_POS, "interpolation index outside window")
	`ASSERT_NEXT(a_flush_clears, clk, arst_n, cmd_valid && cmd_ready && cmd.op == OP_FLUSH, held_q == 2'd0 && phase_q == '0, "flush did not clear stream state")
	`ASSERT_NEXT(a_stall_freezes, clk, arst_n, out_valid_q && !m_axis_tready, $stable(v_s1) && $stable(v_s2), "pipeline moved during output stall")

endmodule

>>> src/streaming_linear_resampler_top.sv
// Linear-interpolation sample rate converter.
// Input words arrive on s_axis: tdata carries a signed 16-bit sample, tuser[0]
// selects the operation (0 pushes the sample, 1 flushes the end of the stream).
// Output words leave on m_axis: tdata is the interpolated sample, tuser[0] marks
// the flush tail word, and tlast marks the final word caused by one input word.
// The output spacing is set by step_ratio (input rate over output rate, Q8.16),
// written through cfg_we and cfg_wdata while the block is idle.
// An input word passes a one-word input register and a short command queue
// before the engine takes it. The engine first loads a push into its window,
// then, while the output is not stalled, issues one output word per cycle
// (at most MAX_UPSAMPLE per push) into a three-stage multiply pipeline, and
// then updates its held samples. A flush is issued straight from the idle state.
// Reset sets step_ratio to 1.0 and clears the held samples and the phase.
// When the receiver stalls, the output register holds its word, the pipeline
// and the engine's issuing freeze, the queue fills and s_axis_tready then falls.
module streaming_linear_resampler_top import slr_pkg::*; #(
	parameter int FRAC_BITS    = FRAC_BITS_DEF,
	parameter int MAX_UPSAMPLE = MAX_UPSAMPLE_DEF,
	parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	input  logic [SAMPLE_W-1:0]     s_axis_tdata,   // [15:0] sample
	input  logic [0:0]              s_axis_tuser,   // [0] operation
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	output logic [SAMPLE_W-1:0]     m_axis_tdata,   // [15:0] value
	output logic [0:0]              m_axis_tuser,   // [0] end_of_stream
	output logic                    m_axis_tlast,
	input  logic                    cfg_we,
	input  logic [STEP_RATIO_W-1:0] cfg_wdata
);

	// The engine reads the step register on every output word of a push, so the user must write
	// it only while the block is idle; the block does not enforce this. A write applies to the next word.
	logic [STEP_RATIO_W-1:0] step_q;

	logic fq_valid, fq_ready;
	cmd_t fq_cmd;
	logic bq_valid, bq_ready;
	cmd_t bq_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
		end else if (cfg_we) begin
			step_q <= cfg_wdata;
		end
	end

	// Front end: registers each input word and decodes its operation.
	slr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_valid       (fq_valid),
		.q_ready       (fq_ready),
		.q_cmd         (fq_cmd)
	);

	// Command queue so the front end keeps accepting while the engine emits.
	slr_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_cmd    (fq_cmd),
		.out_valid (bq_valid),
		.out_ready (bq_ready),
		.out_cmd   (bq_cmd)
	);

	// Engine: phase stepping, interpolation pipeline and output register.
	slr_back #(
		.FRAC_BITS    (FRAC_BITS),
		.MAX_UPSAMPLE (MAX_UPSAMPLE)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (bq_valid),
		.cmd_ready     (bq_ready),
		.cmd           (bq_cmd),
		.step_ratio    (step_q),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

>>> tb/sv/resample_check_pkg.sv
package resample_check_pkg;
	import slr_pkg::*;

	localparam longint unsigned ONE_POS    = longint'(1) << FRAC_BITS_DEF;
	localparam longint unsigned FRAC_MASK  = ONE_POS - 1;
	localparam longint unsigned MIN_STEP   =
		(ONE_POS + MAX_UPSAMPLE_DEF - 1) / MAX_UPSAMPLE_DEF;
	localparam longint unsigned PHASE_MASK = (longint'(1) << PHASE_W) - 1;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] value;
		logic                       eos;
		logic                       last;
	} out_word_t;

	class resample_checker;
		logic [STEP_RATIO_W-1:0]    ratio;
		logic signed [SAMPLE_W-1:0] older;
		logic signed [SAMPLE_W-1:0] newer;
		int unsigned                held;
		longint unsigned            phase;
		out_word_t                  pending_outputs[$];
		int                         errors;

		function new();
			ratio  = STEP_RESET;
			errors = 0;
			clear_stream();
		endfunction

		function void clear_stream();
			older = '0;
			newer = '0;
			held  = 0;
			phase = 0;
		endfunction

		function void set_ratio(logic [STEP_RATIO_W-1:0] v);
			ratio = v;
		endfunction

		function int pending();
			return pending_outputs.size();
		endfunction

		// a + round((b - a) * frac), ties toward +infinity; an arithmetic
		// shift of the biased product is exactly that floor.
		function logic signed [SAMPLE_W-1:0] interpolate(logic signed [SAMPLE_W-1:0] a,
				logic signed [SAMPLE_W-1:0] b, longint unsigned frac);
			longint prod;
			prod = (longint'(b) - longint'(a)) * longint'(frac) + longint'(ONE_POS >> 1);
			return SAMPLE_W'(longint'(a) + (prod >>> FRAC_BITS_DEF));
		endfunction

		// Called for every accepted input word; appends the words it causes.
		function void take_input_word(op_t op, logic [SAMPLE_W-1:0] smp);
			logic signed [SAMPLE_W-1:0] win[3];
			int unsigned     size;
			int unsigned     d;
			int              n;
			longint unsigned step;
			longint unsigned bound;
			longint unsigned j;
			longint unsigned drop;
			out_word_t       w;

			win[0] = older;
			win[1] = newer;
			win[2] = '0;

			if (op == OP_FLUSH) begin
				if (held > 0) begin
					j       = phase >> FRAC_BITS_DEF;
					w.value = (j < held) ? win[j] : win[held-1];
					w.eos   = 1'b1;
					w.last  = 1'b1;
					pending_outputs = {pending_outputs, w};
				end
				clear_stream();
				return;
			end

			win[held] = smp;
			size      = held + 1;
			step      = longint'(ratio);
			if (step < MIN_STEP)
				step = MIN_STEP;
			bound = longint'(size - 1) << FRAC_BITS_DEF;
			n     = 0;
			while (size >= 2 && n < MAX_UPSAMPLE_DEF && phase + ONE_POS <= bound) begin
				j       = phase >> FRAC_BITS_DEF;
				w.value = interpolate(win[j], win[j+1], phase & FRAC_MASK);
				w.eos   = 1'b0;
				w.last  = 1'b0;
				pending_outputs = {pending_outputs, w};
				n++;
				phase += step;
			end
			if (n > 0) begin
				w      = pending_outputs[pending_outputs.size()-1];
				w.last = 1'b1;
				pending_outputs[pending_outputs.size()-1] = w;
			end

			drop = phase >> FRAC_BITS_DEF;
			d    = (drop < longint'(size - 1)) ? int'(drop) : size - 1;
			if (size - d > 2)
				d = size - 2;
			phase = (phase - (longint'(d) << FRAC_BITS_DEF)) & PHASE_MASK;
			older = win[d];
			newer = (size - d == 2) ? win[d+1] : '0;
			held  = size - d;
		endfunction

		function void match_output_word(logic [SAMPLE_W-1:0] value, logic eos, logic last);
			out_word_t e;
			if (pending_outputs.size() == 0) begin
				errors++;
				$error("unexpected output word: value %0d eos %0b last %0b",
					$signed(value), eos, last);
				return;
			end
			e = pending_outputs.pop_front();
			if (value !== e.value) begin
				errors++;
				$error("value: expected %0d, actual %0d", e.value, $signed(value));
			end
			if (eos !== e.eos) begin
				errors++;
				$error("end_of_stream: expected %0b, actual %0b", e.eos, eos);
			end
			if (last !== e.last) begin
				errors++;
				$error("last: expected %0b, actual %0b", e.last, last);
			end
		endfunction
	endclass

endpackage

>>> tb/sv/tb.sv
// Block-level test of the streaming linear resampler.
// Input words are pushed through s_axis with random gaps, and the output side
// applies random backpressure. Every accepted input word is handed to a
// checker object that keeps its own copy of the held samples, the phase and
// the step ratio, and queues the output words it expects. Each output word
// taken from m_axis is compared field by field against the oldest of them.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import slr_pkg::*;
	import resample_check_pkg::*;

	// Generous bound: every push yielding 64 words, each stalled for the
	// longest backpressure stretch, with margin on top.
	localparam int CYCLE_LIMIT = 6_000_000;
	// Cycles allowed for words that cause no output to drain through the
	// input register, the queue and the engine before the block counts as idle.
	localparam int SETTLE_CYCLES = 4 * (MAX_UPSAMPLE_DEF + 2) + 32;

	logic                    clk;
	logic                    arst_n;
	logic                    s_axis_tvalid;
	logic                    s_axis_tready;
	logic [SAMPLE_W-1:0]     s_axis_tdata;
	logic [0:0]              s_axis_tuser;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [SAMPLE_W-1:0]     m_axis_tdata;
	logic [0:0]              m_axis_tuser;
	logic                    m_axis_tlast;
	logic                    cfg_we;
	logic [STEP_RATIO_W-1:0] cfg_wdata;

	resample_checker chk;
	int              cycle_count = 0;
	int              ready_left = 0;
	int              ready_roll;

	streaming_linear_resampler_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // [15:0] sample
		.s_axis_tuser  (s_axis_tuser),   // [0] operation
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),   // [15:0] value
		.m_axis_tuser  (m_axis_tuser),   // [0] end_of_stream
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// Receiver backpressure. Mostly ready for long stretches, with short
	// stalls and now and then a long one, so stalls land on every stage of
	// the engine's work.
	always @(posedge clk) begin
		if (ready_left > 0) begin
			ready_left <= ready_left - 1;
		end else begin
			ready_roll = $urandom_range(0, 99);
			if (ready_roll < 70) begin
				m_axis_tready <= 1'b1;
				ready_left    <= $urandom_range(0, 30);
			end else if (ready_roll < 95) begin
				m_axis_tready <= 1'b0;
				ready_left    <= $urandom_range(0, 2);
			end else begin
				m_axis_tready <= 1'b0;
				ready_left    <= $urandom_range(20, 60);
			end
		end
	end

	// Output monitor. Signals read right after the edge still hold the values
	// the block saw at that edge.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			chk.match_output_word(m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
	end

	// Drives one input word and returns at the edge where it was accepted.
	// The valid is only lowered when a gap follows, so back-to-back words
	// keep it high without a second assignment in the same step.
	task automatic send_word(op_t op, logic [SAMPLE_W-1:0] smp);
		int roll;
		int gap;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			gap = 0;
		else if (roll < 92)
			gap = $urandom_range(1, 4);
		else
			gap = $urandom_range(15, 80);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= smp;
		s_axis_tuser  <= op;
		do @(posedge clk); while (!s_axis_tready);
		chk.take_input_word(op, smp);
	endtask

	// Waits until every expected word has come out and words that cause no
	// output have had time to leave the engine.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (chk.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// The step ratio is only changed while the block is idle.
	task automatic write_ratio(logic [STEP_RATIO_W-1:0] v);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		chk.set_ratio(v);
	endtask

	// Random words: mostly pushes, some flushes. The sample field is random
	// on flushes too, since the block must ignore it there.
	task automatic run_random(int count, int flush_pct);
		int roll;
		logic [SAMPLE_W-1:0] smp;
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 15) begin
				case ($urandom_range(0, 4))
					0: smp = 16'h7FFF;
					1: smp = 16'h8000;
					2: smp = 16'h0000;
					3: smp = 16'hFFFF;
					default: smp = 16'h0001;
				endcase
			end else begin
				smp = SAMPLE_W'($urandom);
			end
			if ($urandom_range(0, 99) < flush_pct)
				send_word(OP_FLUSH, smp);
			else
				send_word(OP_PUSH, smp);
		end
	endtask

	initial begin
		chk = new();
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= OP_PUSH;
		cfg_we        <= 1'b0;
		cfg_wdata     <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset ratio of 1.0: a flush with nothing held,
		// full-scale pushes, a flush with samples held (its sample field set),
		// and a flush right after a single held sample.
		send_word(OP_FLUSH, 16'h1234);
		send_word(OP_PUSH, 16'h7FFF);
		send_word(OP_PUSH, 16'h8000);
		send_word(OP_PUSH, 16'h0000);
		send_word(OP_FLUSH, 16'hFFFF);
		send_word(OP_PUSH, 16'h0005);
		send_word(OP_FLUSH, 16'h0000);

		// Ratio 0.5: every other output sits halfway, which exercises the
		// largest differences and the rounding of ties in both directions.
		write_ratio(24'h008000);
		send_word(OP_PUSH, 16'h7FFF);
		send_word(OP_PUSH, 16'h8000);
		send_word(OP_PUSH, 16'h7FFF);
		send_word(OP_PUSH, 16'h0000);
		send_word(OP_PUSH, 16'h0001);
		send_word(OP_PUSH, 16'h0000);
		send_word(OP_PUSH, 16'hFFFF);
		send_word(OP_PUSH, 16'h8000);
		send_word(OP_FLUSH, 16'h5555);

		// A zero step is raised to the minimum; the pushes here follow a flush, so
		// they do not reach the maximum number of words.
		write_ratio(24'h000000);
		send_word(OP_PUSH, 16'h7FFF);
		send_word(OP_PUSH, 16'h8000);
		send_word(OP_FLUSH, 16'hAAAA);

		// Largest step: the phase runs past the held samples, so the flush
		// returns the newest one.
		write_ratio(24'hFFFFFF);
		send_word(OP_PUSH, 16'd100);
		send_word(OP_PUSH, 16'd200);
		send_word(OP_PUSH, 16'd300);
		send_word(OP_FLUSH, 16'h0F0F);

		// Random part over several ratios, the extremes among them.
		write_ratio(24'd1024);
		run_random(30, 8);
		write_ratio(24'hFFFFFF);
		run_random(30, 25);
		write_ratio(STEP_RESET);
		run_random(35, 10);
		write_ratio(STEP_RATIO_W'($urandom_range(1024, 65535)));
		run_random(40, 8);
		write_ratio(STEP_RATIO_W'($urandom_range(65536, 262143)));
		run_random(40, 8);
		write_ratio(STEP_RATIO_W'($urandom_range(0, 1023)));
		run_random(25, 10);
		write_ratio(STEP_RATIO_W'($urandom_range(1024, 16777215)));
		run_random(40, 15);
		write_ratio(STEP_RATIO_W'($urandom_range(16384, 131071)));
		run_random(40, 5);

		wait_drained();
		if (chk.errors == 0 && chk.pending() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("Regression FAIL");
		$finish;
	end

endmodule

>>> streaming_linear_resampler_top.f
+incdir+src
src/slr_pkg.sv
src/slr_front.sv
src/slr_fifo.sv
src/slr_back.sv
src/streaming_linear_resampler_top.sv
tb/sv/resample_check_pkg.sv
tb/sv/tb.sv
